>>> rtl/arp_pkg.sv
// ----------------------------------------------------------------------------
// arp_pkg
// Shared types and constants for the AArch64 relocation patch core:
// relocation type numbers, internal operation codes and the queue entry.
// ----------------------------------------------------------------------------
package arp_pkg;

	// relocation type numbers (AArch64 ELF ABI)
	localparam logic [9:0] T_NONE           = 10'd0;
	localparam logic [9:0] T_ABS64          = 10'd257;
	localparam logic [9:0] T_ABS32          = 10'd258;
	localparam logic [9:0] T_PREL32         = 10'd261;
	localparam logic [9:0] T_MOVW_G0        = 10'd264;
	localparam logic [9:0] T_MOVW_G1        = 10'd266;
	localparam logic [9:0] T_MOVW_G2        = 10'd268;
	localparam logic [9:0] T_MOVW_G3        = 10'd270;
	localparam logic [9:0] T_ADR_PG_HI21    = 10'd275;
	localparam logic [9:0] T_ADD_LO12       = 10'd277;
	localparam logic [9:0] T_LDST8_LO12     = 10'd278;
	localparam logic [9:0] T_JUMP26         = 10'd282;
	localparam logic [9:0] T_CALL26         = 10'd283;
	localparam logic [9:0] T_LDST32_LO12    = 10'd285;
	localparam logic [9:0] T_LDST64_LO12    = 10'd286;
	localparam logic [9:0] T_ADR_GOT_PAGE   = 10'd311;
	localparam logic [9:0] T_GOT_LO12       = 10'd312;
	localparam logic [9:0] T_GOTPAGE_LO15   = 10'd313;
	localparam logic [9:0] T_IE_PAGE21      = 10'd541;
	localparam logic [9:0] T_IE_LO12        = 10'd542;
	localparam logic [9:0] T_LE_HI12        = 10'd549;
	localparam logic [9:0] T_LE_LO12        = 10'd551;
	localparam logic [9:0] T_DESC_PAGE21    = 10'd562;
	localparam logic [9:0] T_DESC_LD64_LO12 = 10'd563;
	localparam logic [9:0] T_DESC_ADD_LO12  = 10'd564;
	localparam logic [9:0] T_DESC_CALL      = 10'd569;

	// configuration register indexes
	localparam logic REG_GOT_BASE = 1'b0;
	localparam logic REG_TLS_BASE = 1'b1;

	// write sizes
	localparam logic [1:0] WS_NONE  = 2'd0;
	localparam logic [1:0] WS_FOUR  = 2'd1;
	localparam logic [1:0] WS_EIGHT = 2'd2;

	// tls block offset added to tprel values
	localparam logic [23:0] TLS_TCB_SIZE = 24'd16;

	// internal operation codes
	typedef logic [4:0] op_t;
	localparam op_t OP_NONE       = 5'd0;
	localparam op_t OP_BAD        = 5'd1;
	localparam op_t OP_ABS64      = 5'd2;
	localparam op_t OP_ABS32      = 5'd3;
	localparam op_t OP_LO12       = 5'd4;
	localparam op_t OP_LO12_S4    = 5'd5;
	localparam op_t OP_LO12_S8    = 5'd6;
	localparam op_t OP_MOVW0      = 5'd7;
	localparam op_t OP_MOVW1      = 5'd8;
	localparam op_t OP_MOVW2      = 5'd9;
	localparam op_t OP_MOVW3      = 5'd10;
	localparam op_t OP_ADRP_SA    = 5'd11;
	localparam op_t OP_ADRP_EA    = 5'd12;
	localparam op_t OP_BR26       = 5'd13;
	localparam op_t OP_PREL32     = 5'd14;
	localparam op_t OP_EA_LO12_S8 = 5'd15;
	localparam op_t OP_EA_LO12    = 5'd16;
	localparam op_t OP_GOT_LO15   = 5'd17;
	localparam op_t OP_LE_HI12    = 5'd18;
	localparam op_t OP_LE_LO12    = 5'd19;

	// one classified relocation waiting for the back end
	typedef struct packed {
		op_t         op;
		logic [31:0] insn;
		logic [63:0] sa;
		logic [63:0] ea;
		logic [63:0] place;
		logic        undef_sym;
	} qent_t;

endpackage

>>> rtl/aarch64_reloc_patch_core.sv
// ----------------------------------------------------------------------------
// aarch64_reloc_patch_core
// Patches one AArch64 ELF static relocation per beat: takes the type, the
// existing word, S, A, P and the slot address, returns the patched word.
// ----------------------------------------------------------------------------
// Rate: one relocation is taken every clock cycle unless the queue is full.
// Its result beat is registered in the front-end queue and then in the
// back-end output register, which drives the result outputs. The front end
// decodes the type and forms S+A and entry+A with two 64-bit adders feeding
// the queue; the back end forms the narrow pc-relative, page and tls values
// and inserts the field. The queue (QUEUE_DEPTH entries) lets input and
// output stall independently; input ready drops only when the queue is full.
// The user must write got_base and tls_base (plain cfg port) only while the
// block is idle; the block does not enforce it. Only needed bits are kept.
// Unsupported types give bad_type with no write instead of stopping.
// ----------------------------------------------------------------------------
module aarch64_reloc_patch_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_wdata,
	// relocation input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [9:0]  reloc_type,
	input  logic [63:0] orig_word,
	input  logic [63:0] sym_addr,
	input  logic signed [63:0] addend,
	input  logic [63:0] place,
	input  logic [63:0] entry_addr,
	input  logic        undef_weak,
	input  logic        nonalloc,
	// patched result
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] new_word,
	output logic [1:0]  write_size,
	output logic        bad_type
);

	// page bits [14:12] of got_base, all the lo15 form needs
	logic [2:0]     got_page_q;
	// 16 - tls_base, low 24 bits: tprel becomes one add of S+A
	logic [23:0]    tls_off_q;

	arp_pkg::qent_t front_ent;
	arp_pkg::qent_t head_ent;
	logic           head_valid;
	logic           head_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			got_page_q <= '0;
			tls_off_q  <= arp_pkg::TLS_TCB_SIZE;
		end else if (cfg_we) begin
			if (cfg_index == arp_pkg::REG_GOT_BASE) begin
				got_page_q <= cfg_wdata[14:12];
			end else if (cfg_index == arp_pkg::REG_TLS_BASE) begin
				tls_off_q <= arp_pkg::TLS_TCB_SIZE - cfg_wdata[23:0];
			end
		end
	end

	// classify and form the wide sums
	arp_front u_front (
		.reloc_type (reloc_type),
		.insn       (orig_word[31:0]),
		.sym_addr   (sym_addr),
		.addend     (addend),
		.place      (place),
		.entry_addr (entry_addr),
		.undef_weak (undef_weak),
		.nonalloc   (nonalloc),
		.ent        (front_ent)
	);

	// decoupling queue
	arp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_data  (front_ent),
		.pop_valid  (head_valid),
		.pop_ready  (head_ready),
		.pop_data   (head_ent)
	);

	// field insertion and output register
	arp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (head_valid),
		.q_ready    (head_ready),
		.q_data     (head_ent),
		.got_page   (got_page_q),
		.tls_off    (tls_off_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.new_word   (new_word),
		.write_size (write_size),
		.bad_type   (bad_type)
	);

endmodule

>>> rtl/arp_front.sv
// ----------------------------------------------------------------------------
// arp_front
// Front end: classifies the relocation type and forms S+A and entry+A.
// ----------------------------------------------------------------------------
module arp_front (
	input  logic [9:0]         reloc_type,
	input  logic [31:0]        insn,
	input  logic [63:0]        sym_addr,
	input  logic signed [63:0] addend,
	input  logic [63:0]        place,
	input  logic [63:0]        entry_addr,
	input  logic               undef_weak,
	input  logic               nonalloc,
	output arp_pkg::qent_t     ent
);

	arp_pkg::op_t op;

	always_comb begin
		if (reloc_type == arp_pkg::T_NONE) begin
			op = arp_pkg::OP_NONE;
		end else if (nonalloc) begin
			if (reloc_type == arp_pkg::T_ABS64) begin
				op = arp_pkg::OP_ABS64;
			end else if (reloc_type == arp_pkg::T_ABS32) begin
				op = arp_pkg::OP_ABS32;
			end else begin
				op = arp_pkg::OP_BAD;
			end
		end else begin
			unique case (reloc_type) inside
				arp_pkg::T_ABS64:                        op = arp_pkg::OP_ABS64;
				arp_pkg::T_ADD_LO12, arp_pkg::T_LDST8_LO12: op = arp_pkg::OP_LO12;
				arp_pkg::T_LDST32_LO12:                  op = arp_pkg::OP_LO12_S4;
				arp_pkg::T_LDST64_LO12:                  op = arp_pkg::OP_LO12_S8;
				arp_pkg::T_MOVW_G0:                      op = arp_pkg::OP_MOVW0;
				arp_pkg::T_MOVW_G1:                      op = arp_pkg::OP_MOVW1;
				arp_pkg::T_MOVW_G2:                      op = arp_pkg::OP_MOVW2;
				arp_pkg::T_MOVW_G3:                      op = arp_pkg::OP_MOVW3;
				arp_pkg::T_ADR_PG_HI21:                  op = arp_pkg::OP_ADRP_SA;
				arp_pkg::T_ADR_GOT_PAGE, arp_pkg::T_IE_PAGE21,
				arp_pkg::T_DESC_PAGE21:                  op = arp_pkg::OP_ADRP_EA;
				arp_pkg::T_CALL26, arp_pkg::T_JUMP26:    op = arp_pkg::OP_BR26;
				arp_pkg::T_PREL32:                       op = arp_pkg::OP_PREL32;
				arp_pkg::T_GOT_LO12, arp_pkg::T_IE_LO12,
				arp_pkg::T_DESC_LD64_LO12:               op = arp_pkg::OP_EA_LO12_S8;
				arp_pkg::T_DESC_ADD_LO12:                op = arp_pkg::OP_EA_LO12;
				arp_pkg::T_GOTPAGE_LO15:                 op = arp_pkg::OP_GOT_LO15;
				arp_pkg::T_LE_HI12:                      op = arp_pkg::OP_LE_HI12;
				arp_pkg::T_LE_LO12:                      op = arp_pkg::OP_LE_LO12;
				arp_pkg::T_DESC_CALL:                    op = arp_pkg::OP_NONE;
				default:                                 op = arp_pkg::OP_BAD;
			endcase
		end
	end

	always_comb begin
		ent.op        = op;
		ent.insn      = insn;
		ent.sa        = sym_addr + $unsigned(addend);
		ent.ea        = entry_addr + $unsigned(addend);
		ent.place     = place;
		ent.undef_sym = undef_weak;
	end

endmodule

>>> rtl/arp_queue.sv
// ----------------------------------------------------------------------------
// arp_queue
// Short first-in first-out queue of classified relocations between the
// front end and the back end.
// ----------------------------------------------------------------------------
module arp_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  arp_pkg::qent_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output arp_pkg::qent_t pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	arp_pkg::qent_t     mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;
	logic               pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid & push_ready;
	assign pop        = pop_valid & pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue fill count beyond depth");

	a_push_only_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue fill count did not grow on push");
`endif

endmodule

>>> rtl/arp_back.sv
// ----------------------------------------------------------------------------
// arp_back
// Back end: forms the pc-relative, page and tls values, inserts the field
// into the instruction and holds the result in the output register.
// ----------------------------------------------------------------------------
module arp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_ready,
	input  arp_pkg::qent_t q_data,
	input  logic [2:0]     got_page,
	input  logic [23:0]    tls_off,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [63:0]    new_word,
	output logic [1:0]     write_size,
	output logic           bad_type
);

	logic        out_valid_q;
	logic [63:0] new_word_q;
	logic [1:0]  write_size_q;
	logic        bad_type_q;

	logic [31:0] rel;
	logic [20:0] pg_sa;
	logic [20:0] pg_ea;
	logic [14:0] got_off;
	logic [23:0] tp;
	logic [31:0] insn;
	logic [31:0] res_insn;
	logic [63:0] res_word;
	logic [1:0]  res_size;
	logic        res_bad;
	logic        take;

	assign insn    = q_data.insn;
	assign rel     = q_data.sa[31:0] - q_data.place[31:0];
	assign pg_sa   = q_data.sa[32:12] - q_data.place[32:12];
	assign pg_ea   = q_data.ea[32:12] - q_data.place[32:12];
	assign got_off = q_data.ea[14:0] - {got_page, 12'd0};
	assign tp      = q_data.sa[23:0] + tls_off;

	always_comb begin
		res_insn = insn;
		res_size = arp_pkg::WS_FOUR;
		res_bad  = 1'b0;
		res_word = '0;
		unique case (q_data.op)
			arp_pkg::OP_NONE: res_size = arp_pkg::WS_NONE;
			arp_pkg::OP_BAD: begin
				res_size = arp_pkg::WS_NONE;
				res_bad  = 1'b1;
			end
			arp_pkg::OP_ABS64:      res_size = arp_pkg::WS_EIGHT;
			arp_pkg::OP_ABS32:      res_insn = q_data.sa[31:0];
			arp_pkg::OP_LO12:       res_insn = insn | {10'd0, q_data.sa[11:0], 10'd0};
			arp_pkg::OP_LO12_S4:    res_insn = insn | {12'd0, q_data.sa[11:2], 10'd0};
			arp_pkg::OP_LO12_S8:    res_insn = insn | {13'd0, q_data.sa[11:3], 10'd0};
			arp_pkg::OP_MOVW0:      res_insn = insn | {11'd0, q_data.sa[15:0], 5'd0};
			arp_pkg::OP_MOVW1:      res_insn = insn | {11'd0, q_data.sa[31:16], 5'd0};
			arp_pkg::OP_MOVW2:      res_insn = insn | {11'd0, q_data.sa[47:32], 5'd0};
			arp_pkg::OP_MOVW3:      res_insn = insn | {11'd0, q_data.sa[63:48], 5'd0};
			arp_pkg::OP_ADRP_SA:
				res_insn = {insn[31], pg_sa[1:0], insn[28:24], pg_sa[20:2], insn[4:0]};
			arp_pkg::OP_ADRP_EA:
				res_insn = {insn[31], pg_ea[1:0], insn[28:24], pg_ea[20:2], insn[4:0]};
			arp_pkg::OP_BR26:
				res_insn = q_data.undef_sym ? (insn | 32'd1) : (insn | {6'd0, rel[27:2]});
			arp_pkg::OP_PREL32:     res_insn = rel;
			arp_pkg::OP_EA_LO12_S8: res_insn = insn | {13'd0, q_data.ea[11:3], 10'd0};
			arp_pkg::OP_EA_LO12:    res_insn = insn | {10'd0, q_data.ea[11:0], 10'd0};
			arp_pkg::OP_GOT_LO15:   res_insn = insn | {10'd0, got_off[14:3], 10'd0};
			arp_pkg::OP_LE_HI12:    res_insn = insn | {10'd0, tp[23:12], 10'd0};
			arp_pkg::OP_LE_LO12:    res_insn = insn | {10'd0, tp[11:0], 10'd0};
			default: begin
				res_size = arp_pkg::WS_NONE;
				res_bad  = 1'b1;
			end
		endcase
		if (res_size == arp_pkg::WS_EIGHT) begin
			res_word = q_data.sa;
		end else if (res_size == arp_pkg::WS_FOUR) begin
			res_word = {32'd0, res_insn};
		end
	end

	assign q_ready = !out_valid_q || out_ready;
	assign take    = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (take) begin
			new_word_q   <= res_word;
			write_size_q <= res_size;
			bad_type_q   <= res_bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_ready) begin
			out_valid_q <= q_valid;
		end
	end

	assign out_valid  = out_valid_q;
	assign new_word   = new_word_q;
	assign write_size = write_size_q;
	assign bad_type   = bad_type_q;

`ifndef NO_ASSERTIONS
	a_bad_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && bad_type_q) |-> (write_size_q == arp_pkg::WS_NONE))
		else $error("unsupported type carries a write");

	a_size_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (write_size_q != 2'd3))
		else $error("illegal write size");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && write_size_q == arp_pkg::WS_NONE) |-> (new_word_q == '0))
		else $error("skipped relocation has a non-zero word");
`endif

endmodule
